>>> rtl/core/hdu_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register map of the half-duplex 8N1 transceiver.
package hdu_pkg;

  localparam int DATA_BITS  = 8;
  localparam int FRAME_BITS = DATA_BITS + 2;
  localparam int BIDX_W     = $clog2(FRAME_BITS + 1);
  localparam int TICK_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  localparam logic [TICK_W-1:0] DEFAULT_TICKS = TICK_W'(13 * 4);

  // register index, taken from paddr[2]
  localparam logic REG_BIT_PERIOD   = 1'b0;
  localparam logic REG_FIRST_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TX   = 2'd1,
    MODE_RX   = 2'd2
  } mode_t;

  typedef struct packed {
    logic              tx_line;
    logic              tx_busy;
    logic              rx_busy;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
  } result_t;

endpackage

>>> rtl/core/hdu_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
interface hdu_in_if
  import hdu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] send_byte;
  logic              rx_level;

  modport source (output valid, action, send_byte, rx_level, input ready);
  modport sink   (input valid, action, send_byte, rx_level, output ready);
endinterface

interface hdu_out_if
  import hdu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              tx_line;
  logic              tx_busy;
  logic              rx_busy;
  logic              rx_valid;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, tx_line, tx_busy, rx_busy, rx_valid, rx_byte, input ready);
  modport sink   (input valid, tx_line, tx_busy, rx_busy, rx_valid, rx_byte, output ready);
endinterface

>>> rtl/core/half_duplex_uart_8n1.sv
`timescale 1ns / 1ps
// Top level: tick-paced half-duplex 8N1 transceiver with APB register port.
//
//  channel   dir  handshake        beat carries
//  items     in   valid/ready      action, send_byte, rx_level
//  results   out  valid/ready      tx_line, tx_busy, rx_busy, rx_valid, rx_byte
//  apb       in   psel/penable     bit_period (0x0), first_sample_delay (0x4)
//
// One item per clock while items.ready is high: the state update for an item is a
// single pass of logic from the state registers, written at the accepting edge;
// the result is captured into the output stage at that same edge and offered
// from the next cycle unless an older result is still held in the output register.
// A two-entry output stage (output register plus skid) keeps items.ready high
// while one result waits; ready drops only when both entries are full.
// rst (synchronous) returns the line to mark, the block to idle and both
// registers to 52 ticks; the output stage empties.
module half_duplex_uart_8n1
  import hdu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  hdu_in_if.sink            items,
  hdu_out_if.source         results,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------- registers
  logic [TICK_W-1:0] bit_period;
  logic [TICK_W-1:0] first_sample_delay;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period         <= DEFAULT_TICKS;
      first_sample_delay <= DEFAULT_TICKS;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BIT_PERIOD:   bit_period         <= pwdata[TICK_W-1:0];
        REG_FIRST_SAMPLE: first_sample_delay <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BIT_PERIOD:   prdata = {{(APB_DW-TICK_W){1'b0}}, bit_period};
      REG_FIRST_SAMPLE: prdata = {{(APB_DW-TICK_W){1'b0}}, first_sample_delay};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- frame state
  mode_t                 mode,          mode_next;
  logic [TICK_W-1:0]     tick_count,    tick_count_next;
  logic [BIDX_W-1:0]     bit_index,     bit_index_next;
  logic [FRAME_BITS-1:0] tx_shift,      tx_shift_next;
  logic [DATA_BITS-1:0]  rx_shift,      rx_shift_next;
  logic                  line_out,      line_out_next;
  logic                  prev_rx_level, prev_rx_level_next;
  logic                  valid_next;

  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] target;
  logic              period_done;
  logic              accept;
  result_t           res;

  assign accept = items.valid && items.ready;

  // Period counter: wraps at 16 bits, and a wrap also ends the period, so a
  // target below the current count (register rewritten mid-frame) or zero
  // still closes on the next tick.
  assign tick_inc    = tick_count + TICK_W'(1);
  assign target      = (mode == MODE_RX && bit_index == '0) ? first_sample_delay : bit_period;
  assign period_done = (tick_inc >= target) || (tick_inc == '0);

  // next-state logic
  always_comb begin
    mode_next          = mode;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    tx_shift_next      = tx_shift;
    rx_shift_next      = rx_shift;
    line_out_next      = line_out;
    prev_rx_level_next = prev_rx_level;
    valid_next         = 1'b0;

    if (items.action) begin
      // send request: taken only when idle, and it is no tick
      if (mode != MODE_TX && mode != MODE_RX) begin
        tx_shift_next   = {1'b1, DATA_BITS'(items.send_byte), 1'b0};
        bit_index_next  = BIDX_W'(FRAME_BITS);
        tick_count_next = '0;
        mode_next       = MODE_TX;
      end
    end else begin
      prev_rx_level_next = items.rx_level;
      tick_count_next    = period_done ? '0 : tick_inc;
      case (mode)
        MODE_TX: begin
          if (period_done) begin
            if (bit_index != '0) begin
              line_out_next  = tx_shift[0];
              tx_shift_next  = tx_shift >> 1;
              bit_index_next = bit_index - BIDX_W'(1);
            end else begin
              // extra mark period done
              line_out_next = 1'b1;
              tx_shift_next = '1;
              mode_next     = MODE_IDLE;
            end
          end
        end
        MODE_RX: begin
          if (period_done) begin
            if (bit_index < BIDX_W'(DATA_BITS)) begin
              rx_shift_next  = {items.rx_level, rx_shift[DATA_BITS-1:1]};
              bit_index_next = bit_index + BIDX_W'(1);
            end else begin
              // stop period: no check, byte out, re-arm
              bit_index_next = '0;
              mode_next      = MODE_IDLE;
              valid_next     = 1'b1;
            end
          end
        end
        default: begin
          // idle (and the unused code): watch for a start edge
          tick_count_next = tick_count;
          mode_next       = MODE_IDLE;
          if (prev_rx_level && !items.rx_level) begin
            mode_next       = MODE_RX;
            tick_count_next = '0;
            bit_index_next  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      tx_shift      <= '1;
      rx_shift      <= '0;
      line_out      <= 1'b1;
      prev_rx_level <= 1'b1;
    end else if (accept) begin
      mode          <= mode_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      tx_shift      <= tx_shift_next;
      rx_shift      <= rx_shift_next;
      line_out      <= line_out_next;
      prev_rx_level <= prev_rx_level_next;
    end
  end

  // result logic: the state after the item
  always_comb begin
    res.tx_line  = line_out_next;
    res.tx_busy  = (mode_next == MODE_TX);
    res.rx_busy  = (mode_next == MODE_RX);
    res.rx_valid = valid_next;
    res.rx_byte  = (mode_next == MODE_RX) ? '0 : BYTE_W'(rx_shift_next);
  end

  // ---------------------------------------------------------- output stage
  result_t out_data;
  result_t skid_data;
  logic    out_valid;
  logic    skid_valid;
  logic    out_pop;

  assign items.ready = !skid_valid;
  assign out_pop     = out_valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop || !out_valid) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (accept) begin
      skid_data <= res;
    end
  end

  assign results.valid    = out_valid;
  assign results.tx_line  = out_data.tx_line;
  assign results.tx_busy  = out_data.tx_busy;
  assign results.rx_busy  = out_data.rx_busy;
  assign results.rx_valid = out_data.rx_valid;
  assign results.rx_byte  = out_data.rx_byte;

endmodule

>>> rtl/core/hdu_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the transceiver, bound to the top level.
module hdu_checker
  import hdu_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              tx_line,
  input logic              tx_busy,
  input logic              rx_busy,
  input logic              rx_valid,
  input logic [BYTE_W-1:0] rx_byte
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rx_byte) && $stable(rx_valid))
    else $error("result beat changed while stalled");

  // half duplex: never both directions
  a_one_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tx_busy && rx_busy))
    else $error("tx and rx busy together");

  // a completed byte leaves the block idle
  a_valid_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_valid |-> !rx_busy && !tx_busy)
    else $error("rx_valid while busy");

  // byte field is cleared during reception; line idles at mark when not sending
  a_rx_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_busy |-> rx_byte == '0 && tx_line)
    else $error("rx_byte not zero or line not mark during reception");

endmodule

bind half_duplex_uart_8n1 hdu_checker u_hdu_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .tx_line   (results.tx_line),
  .tx_busy   (results.tx_busy),
  .rx_busy   (results.rx_busy),
  .rx_valid  (results.rx_valid),
  .rx_byte   (results.rx_byte)
);

>>> bench/half_duplex_uart_8n1_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the tick-paced half-duplex 8N1 transceiver.
module half_duplex_uart_8n1_test;
  import hdu_pkg::*;

  // Item kinds carried in the action field
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SEND = 1'b1;

  // Generous ceiling on the whole run
  localparam int LIMIT_CYCLES = 400000;
  // Output register latency plus skid entry, with margin
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  hdu_in_if  item_ch ();
  hdu_out_if res_ch ();

  half_duplex_uart_8n1 DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Transceiver model: own copy of registers and state, stepped once per
  // accepted input beat. Register copies follow every APB write.
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0] cfg_bit_period;
  logic [TICK_W-1:0] cfg_first_delay;

  mode_t             st_mode;
  logic [TICK_W-1:0] st_ticks;
  logic [BIDX_W-1:0] st_bit;
  logic [FRAME_BITS-1:0] st_txsh;
  logic [BYTE_W-1:0] st_rxsh;
  logic              st_line;
  logic              st_prev_rx;

  result_t want_outputs[$];   // expected result beats, oldest first
  result_t due;

  int failures       = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int bytes_received = 0;
  int frames_started = 0;
  int cycles         = 0;
  logic gaps_on      = 1'b0;
  int stall_left     = 0;

  // Counter advances each tick; a period closes once the target is reached or
  // passed, or on wrap. A zero target therefore closes on every tick.
  function automatic logic period_over(input logic [TICK_W-1:0] target);
    st_ticks = st_ticks + 1'b1;
    if (st_ticks >= target || st_ticks == '0) begin
      st_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t step_uart_model(input logic act, input logic [BYTE_W-1:0] data,
                                              input logic lvl);
    result_t r;
    logic    done;
    done = 1'b0;
    if (act == ACT_SEND) begin
      // honoured only when idle; the line sample of a send beat is ignored
      if (st_mode == MODE_IDLE) begin
        st_txsh  = {1'b1, data, 1'b0};
        st_bit   = BIDX_W'(FRAME_BITS);
        st_ticks = '0;
        st_mode  = MODE_TX;
        frames_started++;
      end
    end else begin
      case (st_mode)
        MODE_TX: begin
          if (period_over(cfg_bit_period)) begin
            if (st_bit > 0) begin
              st_line = st_txsh[0];
              st_txsh = st_txsh >> 1;
              st_bit--;
            end else begin
              // hold period over: back to mark and idle
              st_line = 1'b1;
              st_txsh = '1;
              st_mode = MODE_IDLE;
            end
          end
        end
        MODE_RX: begin
          if (period_over((st_bit == 0) ? cfg_first_delay : cfg_bit_period)) begin
            if (st_bit < DATA_BITS) begin
              st_rxsh = {lvl, st_rxsh[BYTE_W-1:1]};
              st_bit++;
            end else begin
              // no stop-bit check; an edge on this tick goes unseen
              st_bit  = '0;
              st_mode = MODE_IDLE;
              done    = 1'b1;
            end
          end
        end
        default: begin
          if (st_prev_rx && !lvl) begin
            st_mode  = MODE_RX;
            st_ticks = '0;
            st_bit   = '0;
          end
        end
      endcase
      // follows every tick, also while sending
      st_prev_rx = lvl;
    end
    r.tx_line  = st_line;
    r.tx_busy  = (st_mode == MODE_TX);
    r.rx_busy  = (st_mode == MODE_RX);
    r.rx_valid = done;
    r.rx_byte  = (st_mode == MODE_RX) ? '0 : st_rxsh;
    return r;
  endfunction

  task automatic report_failure(input string what);
    failures++;
    if (failures <= 10) $display("%0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field comparison
  // ---------------------------------------------------------------------------
  function automatic int burst_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 99) < 20) begin
      stall_left = burst_len() - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got)
      report_failure($sformatf("result %0d, %s: expected %h, got %h",
                               results_seen, name, want, got));
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (want_outputs.size() == 0) begin
        report_failure("result beat with nothing expected");
      end else begin
        due = want_outputs.pop_front();
        check_field("tx_line", due.tx_line, res_ch.tx_line);
        check_field("tx_busy", due.tx_busy, res_ch.tx_busy);
        check_field("rx_busy", due.rx_busy, res_ch.rx_busy);
        check_field("rx_valid", due.rx_valid, res_ch.rx_valid);
        check_field("rx_byte", due.rx_byte, res_ch.rx_byte);
        if (due.rx_valid) bytes_received++;
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles, %0d results still due", cycles,
               want_outputs.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Inputs move on the falling edge; acceptance is seen on the rising.
  // valid stays high across back-to-back beats and drops only for a gap or a drain.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic act, input logic [BYTE_W-1:0] data, input logic lvl);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 25) ? burst_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.action    <= act;
    item_ch.send_byte <= data;
    item_ch.rx_level  <= lvl;
    do @(posedge clk); while (!item_ch.ready);
    want_outputs.push_back(step_uart_model(act, data, lvl));
    items_sent++;
  endtask

  task automatic tick(input logic lvl);
    send_item(ACT_TICK, 8'($urandom_range(0, 255)), lvl);
  endtask

  // Stop feeding beats and let every expected result come back
  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (want_outputs.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One APB transfer: setup phase, then access phase until pready
  task automatic apb_access(input logic wr, input logic idx, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) begin
      if (idx == REG_BIT_PERIOD) cfg_bit_period = wdata[TICK_W-1:0];
      else cfg_first_delay = wdata[TICK_W-1:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write, then read back; only called with the item side drained
  task automatic write_reg(input logic idx, input logic [TICK_W-1:0] value);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, idx, APB_DW'(value), rd);
    apb_access(1'b0, idx, '0, rd);
    if (rd[TICK_W-1:0] !== value)
      report_failure($sformatf("register %0d readback: expected %h, got %h",
                               idx, value, rd[TICK_W-1:0]));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Both registers come out of reset at 52 ticks; line idles at mark
  task automatic test_reset_values();
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, REG_BIT_PERIOD, '0, rd);
    if (rd[TICK_W-1:0] !== DEFAULT_TICKS)
      report_failure($sformatf("bit_period after reset: expected %h, got %h",
                               DEFAULT_TICKS, rd[TICK_W-1:0]));
    apb_access(1'b0, REG_FIRST_SAMPLE, '0, rd);
    if (rd[TICK_W-1:0] !== DEFAULT_TICKS)
      report_failure($sformatf("first_sample_delay after reset: expected %h, got %h",
                               DEFAULT_TICKS, rd[TICK_W-1:0]));
    tick(1'b1);
    tick(1'b1);
    drain();
  endtask

  // Short hand-built frames with a zero bit period (every tick ends a period)
  task automatic test_directed_frames();
    logic [BYTE_W-1:0] pattern;
    pattern = 8'h96;   // MSB set, so the low level on the completing tick is a fall
    write_reg(REG_BIT_PERIOD, '0);
    write_reg(REG_FIRST_SAMPLE, 16'd1);
    send_item(ACT_SEND, 8'h00, 1'b1);
    // second send while sending is dropped
    send_item(ACT_SEND, 8'hFF, 1'b0);
    // ten frame bits plus the hold; rx edges in between are ignored
    for (int i = 0; i < 11; i++) tick(~i[0]);
    tick(1'b0);                        // start edge
    send_item(ACT_SEND, 8'h5A, 1'b1);  // dropped while receiving, level ignored
    for (int b = 0; b < BYTE_W; b++) tick(pattern[b]);
    tick(1'b0);                        // completing tick; this fall is not seen
    tick(1'b0);                        // no edge: previous level already low
    tick(1'b1);
    drain();
  endtask

  // Widest periods, then a shorter value written mid-frame takes effect at once
  task automatic test_register_change();
    write_reg(REG_BIT_PERIOD, 16'hFFFF);
    write_reg(REG_FIRST_SAMPLE, 16'hFFFF);
    send_item(ACT_SEND, 8'($urandom_range(0, 255)), 1'b1);
    repeat (40) tick(1'b1);
    drain();
    write_reg(REG_BIT_PERIOD, 16'd2);  // counter already past it
    repeat (30) tick(1'b1);
    tick(1'b0);                        // start edge, first sample far away
    repeat (25) tick(1'($urandom_range(0, 1)));
    drain();
    write_reg(REG_FIRST_SAMPLE, 16'd3);
    repeat (30) tick(1'($urandom_range(0, 1)));
    drain();
  endtask

  // Mixed line traffic: well-formed frames at the current bit rate,
  // with transmit requests, truncated frames and line noise in between
  task automatic stream_traffic(input int budget);
    int                stop_at;
    int                bp;
    int                r;
    int                cut;
    logic [BYTE_W-1:0] data;
    logic [FRAME_BITS-1:0] frame;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      bp = (cfg_bit_period == 0) ? 1 : int'(cfg_bit_period);
      r = $urandom_range(0, 99);
      data = 8'($urandom_range(0, 255));
      if (r < 45) begin
        frame = {1'b1, data, 1'b0};
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : FRAME_BITS;
        for (int k = 0; k < cut; k++) repeat (bp) tick(frame[k]);
        repeat ($urandom_range(1, 2 * bp + 2)) tick(1'b1);
      end else if (r < 70) begin
        send_item(ACT_SEND, data, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(8 * bp, 12 * bp + 2))
          tick(($urandom_range(0, 99) < 15) ? 1'($urandom_range(0, 1)) : 1'b1);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 8)) tick(1'($urandom_range(0, 1)));
      end else begin
        send_item(ACT_SEND, data, 1'($urandom_range(0, 1)));
      end
    end
    drain();
  endtask

  // Several register settings, the narrowest included; one phase runs flat out
  task automatic test_random_traffic();
    logic [TICK_W-1:0] bp_set[7];
    logic [TICK_W-1:0] fd_set[7];
    bp_set = '{16'd1, 16'd1, 16'd2, 16'd3, 16'd2, 16'd4, 16'd0};
    fd_set = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd1, 16'd6, 16'd1};
    bp_set[6] = TICK_W'($urandom_range(1, 5));
    fd_set[6] = TICK_W'($urandom_range(1, 8));
    for (int p = 0; p < 7; p++) begin
      gaps_on = (p != 2);
      write_reg(REG_BIT_PERIOD, bp_set[p]);
      write_reg(REG_FIRST_SAMPLE, fd_set[p]);
      stream_traffic(230);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    item_ch.valid     = 1'b0;
    item_ch.action    = ACT_TICK;
    item_ch.send_byte = '0;
    item_ch.rx_level  = 1'b1;
    res_ch.ready      = 1'b0;

    cfg_bit_period  = DEFAULT_TICKS;
    cfg_first_delay = DEFAULT_TICKS;
    st_mode         = MODE_IDLE;
    st_ticks        = '0;
    st_bit          = '0;
    st_txsh         = '1;
    st_rxsh         = '0;
    st_line         = 1'b1;
    st_prev_rx      = 1'b1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    gaps_on = 1'b1;
    test_directed_frames();
    test_register_change();
    test_random_traffic();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (want_outputs.size() != 0)
      report_failure($sformatf("%0d expected results never arrived", want_outputs.size()));

    $display("Sent %0d item beats (%0d transmit frames started), checked %0d result beats",
             items_sent, frames_started, results_seen);
    $display("Received %0d complete bytes; %0d failures", bytes_received, failures);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/hdu_pkg.sv
rtl/core/hdu_if.sv
rtl/core/half_duplex_uart_8n1.sv
rtl/core/hdu_checker.sv
bench/half_duplex_uart_8n1_test.sv
